// ----- design/fcc_pkg.sv -----
package fcc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValW    = 12;
  localparam int unsigned CntW    = 13;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxEntriesDefault = 4096;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [CntW-1:0] FirstIdx = CntW'(2);

  typedef enum logic [CfgAddrW-1:0] {
    RegEntryCount = 3'd0,
    RegFreeCode   = 3'd1,
    RegDamaged    = 3'd2,
    RegEndLow     = 3'd3,
    RegEndHigh    = 3'd4,
    RegUsedLow    = 3'd5,
    RegUsedHigh   = 3'd6
  } fcc_reg_e;

  typedef struct packed {
    logic [CntW-1:0] entry_count;
    logic [ValW-1:0] free_code;
    logic [ValW-1:0] damaged_code;
    logic [ValW-1:0] end_low;
    logic [ValW-1:0] end_high;
    logic [ValW-1:0] used_low;
    logic [ValW-1:0] used_high;
  } fcc_cfg_t;

  // one table byte's class flags on their way to the counters
  typedef struct packed {
    logic last;
    logic used;
    logic free;
    logic damaged;
    logic eoc;
  } fcc_item_t;

  typedef enum logic [1:0] {
    PhFirst  = 2'd0,
    PhMiddle = 2'd1,
    PhThird  = 2'd2,
    PhSpare  = 2'd3
  } fcc_phase_e;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v, input logic inc);
    logic [CntW-1:0] r;
    r = v;
    if (inc && (v != CntMax)) begin
      r = v + CntW'(1);
    end
    return r;
  endfunction

endpackage

// ----- design/fat12_cluster_census.sv -----
// FAT12 allocation table census. Table bytes stream in on the slave side, one byte a
// cycle with no bubbles while the queue has room; the front unpacks each three-byte
// group into two 12-bit entries and classifies them against the configured codes, a
// two-word queue carries the class flags to the counters, and the byte with tlast set
// yields one result word holding the saturating used, free, damaged and end-of-chain
// counts (entries 0 and 1 and entries from the smaller of entry_count and MAX_ENTRIES
// on are skipped), after which the counts clear. The last byte's flags pass through the
// queue into the output register, which then holds the result. A held result stalls the
// counters only at the next last byte; bytes keep flowing until the queue behind it
// fills. Configuration writes must only be made while no scan is in flight.
module fat12_cluster_census_core
  import fcc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,  // table_byte
  input  logic                s_axis_tlast,  // is_last
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // used, free, damaged, end counts; zero pad
);

  fcc_cfg_t  cfg_q;
  fcc_item_t front_item, back_item;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_count  <= CntW'(4086);
      cfg_q.free_code    <= ValW'(0);
      cfg_q.damaged_code <= ValW'(4087);
      cfg_q.end_low      <= ValW'(4088);
      cfg_q.end_high     <= ValW'(4095);
      cfg_q.used_low     <= ValW'(2);
      cfg_q.used_high    <= ValW'(4079);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegEntryCount: cfg_q.entry_count  <= cfg_data_i;
        RegFreeCode:   cfg_q.free_code    <= cfg_data_i[ValW-1:0];
        RegDamaged:    cfg_q.damaged_code <= cfg_data_i[ValW-1:0];
        RegEndLow:     cfg_q.end_low      <= cfg_data_i[ValW-1:0];
        RegEndHigh:    cfg_q.end_high     <= cfg_data_i[ValW-1:0];
        RegUsedLow:    cfg_q.used_low     <= cfg_data_i[ValW-1:0];
        RegUsedHigh:   cfg_q.used_high    <= cfg_data_i[ValW-1:0];
        default: ;
      endcase
    end
  end

  fcc_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .item_valid_o(front_valid),
    .item_ready_i(front_ready),
    .item_o      (front_item)
  );

  fcc_fifo #(
    .WIDTH($bits(fcc_item_t)),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(front_valid),
    .wr_ready_o(front_ready),
    .wr_data_i (front_item),
    .rd_valid_o(back_valid),
    .rd_ready_i(back_ready),
    .rd_data_o (back_item)
  );

  fcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(back_valid),
    .item_ready_o(back_ready),
    .item_i      (back_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- design/fcc_front.sv -----
module fcc_front
  import fcc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fcc_cfg_t         cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output fcc_item_t        item_o
);

  localparam logic [CntW-1:0] MaxEntries = CntW'(MAX_ENTRIES);

  fcc_phase_e       phase_q, phase_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] middle_q, middle_d;
  logic [CntW-1:0]  idx_q, idx_d;

  logic            accept;
  logic            present;
  logic [ValW-1:0] value;
  logic [CntW-1:0] limit;
  logic            counted;

  assign accept       = in_valid_i && item_ready_i;
  assign in_ready_o   = item_ready_i;
  assign item_valid_o = in_valid_i;
  assign limit = (cfg_i.entry_count > MaxEntries) ? MaxEntries : cfg_i.entry_count;

  always_comb begin
    present  = 1'b0;
    value    = '0;
    phase_d  = phase_q;
    first_d  = first_q;
    middle_d = middle_q;
    unique case (phase_q)
      PhMiddle: begin
        present  = 1'b1;
        value    = {in_byte_i[3:0], first_q};
        middle_d = in_byte_i;
        phase_d  = PhThird;
      end
      PhThird: begin
        present = 1'b1;
        value   = {in_byte_i, middle_q[7:4]};
        phase_d = PhFirst;
      end
      PhFirst, PhSpare: begin
        first_d = in_byte_i;
        phase_d = PhMiddle;
      end
      default: begin
        phase_d = PhFirst;
      end
    endcase
    idx_d   = sat_inc(idx_q, present);
    counted = present && (idx_q >= FirstIdx) && (idx_q < limit);
    if (in_last_i) begin
      phase_d  = PhFirst;
      first_d  = '0;
      middle_d = '0;
      idx_d    = '0;
    end
  end

  always_comb begin
    item_o.last    = in_last_i;
    item_o.free    = counted && (value == cfg_i.free_code);
    item_o.damaged = counted && (value == cfg_i.damaged_code);
    item_o.eoc     = counted && (value >= cfg_i.end_low) && (value <= cfg_i.end_high);
    item_o.used    = counted && (value >= cfg_i.used_low) && (value <= cfg_i.used_high);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      first_q  <= '0;
      middle_q <= '0;
      idx_q    <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      middle_q <= middle_d;
      idx_q    <= idx_d;
    end
  end

endmodule

// ----- design/fcc_fifo.sv -----
module fcc_fifo
  import fcc_pkg::*;
#(
  parameter int unsigned WIDTH = $bits(fcc_item_t),
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntFW = $clog2(DEPTH + 1);
  localparam logic [CntFW-1:0] Full = CntFW'(DEPTH);
  localparam logic [PtrW-1:0]  Last = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntFW-1:0] cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != Full);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == Last) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == Last) ? '0 : rptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntFW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntFW'(1);
      end
    end
  end

endmodule

// ----- design/fcc_back.sv -----
module fcc_back
  import fcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  fcc_item_t           item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic [CntW-1:0] used_q, free_q, dmg_q, eoc_q;
  logic [CntW-1:0] used_d, free_d, dmg_d, eoc_d;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic            pop;

  // the tallies keep running while a finished result waits; only a last word stalls
  assign item_ready_o = !item_i.last || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;

  assign used_d = sat_inc(used_q, item_i.used);
  assign free_d = sat_inc(free_q, item_i.free);
  assign dmg_d  = sat_inc(dmg_q, item_i.damaged);
  assign eoc_d  = sat_inc(eoc_q, item_i.eoc);

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last) begin
      out_data_q <= {(OutDataW - 4 * CntW)'(0), eoc_d, dmg_d, free_d, used_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      free_q      <= '0;
      dmg_q       <= '0;
      eoc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (item_i.last) begin
          used_q <= '0;
          free_q <= '0;
          dmg_q  <= '0;
          eoc_q  <= '0;
        end else begin
          used_q <= used_d;
          free_q <= free_d;
          dmg_q  <= dmg_d;
          eoc_q  <= eoc_d;
        end
      end
      if (pop && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
